// ===== src/takf_pkg.sv =====
// Package for the tilt angle Kalman fusion block.
// Holds the payload and state types, fixed-point constants and helper functions.
// Used by the top level and the checker under src; takf_mul does not import it.
package takf_pkg;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_rate;
    } takf_in_t;

    typedef struct packed {
        logic signed [31:0] angle_estimate;
        logic        [31:0] estimate_uncertainty;
    } takf_out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_SQ_SUM,
        ST_SQRT,
        ST_CORD_INIT,
        ST_CORDIC,
        ST_DEG,
        ST_DEG_WAIT,
        ST_GYRO1,
        ST_GYRO2,
        ST_DIV_INIT,
        ST_DIV,
        ST_CORR_LO,
        ST_CORR_HI,
        ST_CORR_P,
        ST_FINISH
    } takf_state_t;

    typedef enum logic [2:0] {
        REG_STEP_TIME   = 3'd0,
        REG_PROC_NOISE  = 3'd1,
        REG_MEAS_VAR    = 3'd2,
        REG_GYRO_SCALE  = 3'd3
    } takf_reg_idx_t;

    localparam int          ATAN_LEN        = 24;
    localparam logic [31:0] HALF_PI_Q30     = 32'd1686629713;
    localparam logic [25:0] DEG_PER_RAD_Q16 = 26'd3755213;
    localparam logic [24:0] ONE_Q24         = 25'd16777216;

    localparam logic [15:0] STEP_TIME_RST  = 16'd262;
    localparam logic [23:0] PROC_NOISE_RST = 24'd4295;
    localparam logic [23:0] MEAS_VAR_RST   = 24'd167772;
    localparam logic [23:0] GYRO_SCALE_RST = 24'd128070;
    localparam logic [31:0] UNC_RST        = 32'd67108864;

    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'd843314856;
            5'd1:  r = 32'd497837829;
            5'd2:  r = 32'd263043836;
            5'd3:  r = 32'd133525158;
            5'd4:  r = 32'd67021686;
            5'd5:  r = 32'd33543515;
            5'd6:  r = 32'd16775850;
            5'd7:  r = 32'd8388437;
            5'd8:  r = 32'd4194282;
            5'd9:  r = 32'd2097149;
            5'd10: r = 32'd1048575;
            5'd11: r = 32'd524287;
            5'd12: r = 32'd262143;
            5'd13: r = 32'd131071;
            5'd14: r = 32'd65535;
            5'd15: r = 32'd32767;
            5'd16: r = 32'd16383;
            5'd17: r = 32'd8191;
            5'd18: r = 32'd4095;
            5'd19: r = 32'd2047;
            5'd20: r = 32'd1023;
            5'd21: r = 32'd511;
            5'd22: r = 32'd255;
            5'd23: r = 32'd127;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // Divide by 2^s, rounding half away from zero.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int s);
        logic [63:0] mag;
        logic [63:0] res;
        mag = v[63] ? 64'(-v) : 64'(v);
        res = (mag + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(res) : $signed(res);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== src/takf_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on nothing but its operands; used by the top level for every product.
module takf_mul (
    input  logic               aclk,
    input  logic signed [32:0] op_a,
    input  logic signed [25:0] op_b,
    output logic signed [58:0] prod
);
    logic signed [58:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;
endmodule

// ===== src/tilt_angle_kalman_fusion.sv =====
// Tilt angle Kalman fusion: each accepted word carries an accelerometer triple and a
// gyro rate; the block measures tilt with a square root and a vectoring CORDIC, then
// runs a scalar Kalman predict and correct step and returns angle and uncertainty.
// One word occupies the block from acceptance until the result appears and ready rises
// again, so the block works on one word at a time. When ay and az are both zero the
// CORDIC is skipped. Iteration counts above 24 are treated as 24.
// The time is spent in a one-bit-per-cycle square root, one CORDIC
// micro-rotation per cycle, a restoring divider for the gain and one shared
// 33 x 26 multiplier used for every product. The result sits in an output register, so
// the next word can be taken while a result waits to be read; the finishing step then
// holds until that earlier result has been taken.
module tilt_angle_kalman_fusion #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  takf_pkg::takf_in_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output takf_pkg::takf_out_t m_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_wdata
);
    import takf_pkg::*;

    localparam int ITERS = (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERATIONS;
    localparam logic [4:0] ITER_LAST = 5'(ITERS - 1);

    takf_state_t state_reg, state_next;

    logic [15:0] step_time_reg;
    logic [23:0] proc_noise_reg, meas_var_reg, gyro_scale_reg;
    logic signed [31:0] angle_reg, angle_next;
    logic [31:0] unc_reg, unc_next;

    takf_in_t in_reg, in_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic signed [58:0] ysq_reg, ysq_next;
    logic [47:0] rad_reg, rad_next;
    logic [25:0] srem_reg, srem_next;
    logic [23:0] root_reg, root_next;
    logic signed [27:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [31:0] cz_reg, cz_next;
    logic signed [31:0] meas_reg, meas_next;
    logic signed [31:0] pred_reg, pred_next;
    logic [31:0] p_reg, p_next;
    logic [32:0] den_reg, den_next;
    logic [32:0] drem_reg, drem_next;
    logic [24:0] gain_reg, gain_next;
    logic signed [58:0] lo_reg, lo_next;
    logic signed [31:0] newa_reg, newa_next;
    logic        m_valid_reg, m_valid_next;
    takf_out_t   m_data_reg, m_data_next;

    logic signed [32:0] mul_a;
    logic signed [25:0] mul_b;
    logic signed [58:0] prod;

    logic signed [33:0] innov;
    logic               out_free;

    takf_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign innov    = {{2{meas_reg[31]}}, meas_reg} - {{2{pred_reg[31]}}, pred_reg};
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_SQ_Y;
            ST_SQ_Y:      state_next = ST_SQ_Z;
            ST_SQ_Z:      state_next = ST_SQ_SUM;
            ST_SQ_SUM:    state_next = ST_SQRT;
            ST_SQRT:      if (cnt_reg == 5'd23) state_next = ST_CORD_INIT;
            ST_CORD_INIT: state_next = (root_reg == '0) ? ST_DEG : ST_CORDIC;
            ST_CORDIC:    if (cnt_reg == ITER_LAST) state_next = ST_DEG;
            ST_DEG:       state_next = ST_DEG_WAIT;
            ST_DEG_WAIT:  state_next = ST_GYRO1;
            ST_GYRO1:     state_next = ST_GYRO2;
            ST_GYRO2:     state_next = ST_DIV_INIT;
            ST_DIV_INIT:  state_next = ST_DIV;
            ST_DIV:       if (cnt_reg == 5'd24) state_next = ST_CORR_LO;
            ST_CORR_LO:   state_next = ST_CORR_HI;
            ST_CORR_HI:   state_next = ST_CORR_P;
            ST_CORR_P:    state_next = ST_FINISH;
            ST_FINISH:    if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        logic [27:0] t_rem;
        logic [27:0] t_try;
        logic signed [27:0] xs;
        logic signed [27:0] ys;
        logic [33:0] t_div;
        logic signed [63:0] wide;
        logic signed [63:0] delta;
        logic [32:0] psum;
        logic [63:0] pw;

        in_next      = in_reg;
        cnt_next     = cnt_reg;
        ysq_next     = ysq_reg;
        rad_next     = rad_reg;
        srem_next    = srem_reg;
        root_next    = root_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cz_next      = cz_reg;
        meas_next    = meas_reg;
        pred_next    = pred_reg;
        p_next       = p_reg;
        den_next     = den_reg;
        drem_next    = drem_reg;
        gain_next    = gain_reg;
        lo_next      = lo_reg;
        newa_next    = newa_reg;
        angle_next   = angle_reg;
        unc_next     = unc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mul_a        = '0;
        mul_b        = '0;
        t_rem        = '0;
        t_try        = '0;
        xs           = '0;
        ys           = '0;
        t_div        = '0;
        wide         = '0;
        delta        = '0;
        psum         = '0;
        pw           = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next = s_data;
                end
            end
            ST_SQ_Y: begin
                mul_a = 33'(in_reg.accel_y);
                mul_b = 26'(in_reg.accel_y);
            end
            ST_SQ_Z: begin
                mul_a    = 33'(in_reg.accel_z);
                mul_b    = 26'(in_reg.accel_z);
                ysq_next = prod;
            end
            ST_SQ_SUM: begin
                wide      = 64'(ysq_reg) + 64'(prod);
                rad_next  = {wide[31:0], 16'd0};
                srem_next = '0;
                root_next = '0;
                cnt_next  = '0;
            end
            ST_SQRT: begin
                // Restoring square root, one result bit per cycle.
                t_rem = {srem_reg, rad_reg[47:46]};
                t_try = {root_reg, 2'b01};
                if (t_rem >= t_try) begin
                    t_rem     = t_rem - t_try;
                    root_next = {root_reg[22:0], 1'b1};
                end else begin
                    root_next = {root_reg[22:0], 1'b0};
                end
                srem_next = t_rem[25:0];
                rad_next  = {rad_reg[45:0], 2'b00};
                cnt_next  = cnt_reg + 5'd1;
            end
            ST_CORD_INIT: begin
                cx_next  = {4'd0, root_reg};
                cy_next  = {{4{in_reg.accel_x[15]}}, in_reg.accel_x, 8'd0};
                cnt_next = '0;
                if (root_reg != '0) begin
                    cz_next = '0;
                end else if (in_reg.accel_x > 16'sd0) begin
                    cz_next = HALF_PI_Q30;
                end else if (in_reg.accel_x < 16'sd0) begin
                    cz_next = -$signed(HALF_PI_Q30);
                end else begin
                    cz_next = '0;
                end
            end
            ST_CORDIC: begin
                xs = cx_reg >>> cnt_reg;
                ys = cy_reg >>> cnt_reg;
                if (cy_reg > 28'sd0) begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + $signed(atan_q30(cnt_reg));
                end else if (cy_reg < 28'sd0) begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - $signed(atan_q30(cnt_reg));
                end
                cnt_next = cnt_reg + 5'd1;
            end
            ST_DEG: begin
                mul_a = 33'(cz_reg);
                mul_b = DEG_PER_RAD_Q16;
            end
            ST_DEG_WAIT: begin
                wide      = rnd_shift(64'(prod), 30);
                meas_next = wide[31:0];
                mul_a     = 33'(in_reg.gyro_rate);
                mul_b     = {10'd0, step_time_reg};
            end
            ST_GYRO1: begin
                mul_a = prod[32:0];
                mul_b = {2'b00, gyro_scale_reg};
            end
            ST_GYRO2: begin
                delta     = rnd_shift(64'(prod), 24);
                pred_next = sat32(64'(angle_reg) + delta);
                psum      = {1'b0, unc_reg} + {9'd0, proc_noise_reg};
                p_next    = psum[32] ? 32'hFFFFFFFF : psum[31:0];
            end
            ST_DIV_INIT: begin
                den_next  = {1'b0, p_reg} + {9'd0, meas_var_reg};
                drem_next = {2'b00, p_reg[31:1]};
                gain_next = '0;
                cnt_next  = '0;
            end
            ST_DIV: begin
                // Gain quotient bits 24 down to 0; only bit 24 takes a dividend bit.
                t_div = {drem_reg, (cnt_reg == 5'd0) ? p_reg[0] : 1'b0};
                if (den_reg != '0 && t_div >= {1'b0, den_reg}) begin
                    t_div     = t_div - {1'b0, den_reg};
                    gain_next = {gain_reg[23:0], 1'b1};
                end else begin
                    gain_next = {gain_reg[23:0], 1'b0};
                end
                drem_next = t_div[32:0];
                cnt_next  = cnt_reg + 5'd1;
            end
            ST_CORR_LO: begin
                mul_a = {17'd0, innov[15:0]};
                mul_b = {1'b0, gain_reg};
            end
            ST_CORR_HI: begin
                lo_next = prod;
                mul_a   = 33'($signed(innov[33:16]));
                mul_b   = {1'b0, gain_reg};
            end
            ST_CORR_P: begin
                wide      = (64'(prod) <<< 16) + 64'(lo_reg);
                delta     = rnd_shift(wide, 24);
                newa_next = sat32(64'(pred_reg) + delta);
                mul_a     = {1'b0, p_reg};
                mul_b     = {1'b0, ONE_Q24 - gain_reg};
            end
            ST_FINISH: begin
                mul_a = {1'b0, p_reg};
                mul_b = {1'b0, ONE_Q24 - gain_reg};
                pw    = 64'(prod) + 64'd8388608;
                if (out_free) begin
                    angle_next   = newa_reg;
                    unc_next     = pw[55:24];
                    m_valid_next = 1'b1;
                    m_data_next.angle_estimate       = newa_reg;
                    m_data_next.estimate_uncertainty = pw[55:24];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            angle_reg      <= '0;
            unc_reg        <= UNC_RST;
            step_time_reg  <= STEP_TIME_RST;
            proc_noise_reg <= PROC_NOISE_RST;
            meas_var_reg   <= MEAS_VAR_RST;
            gyro_scale_reg <= GYRO_SCALE_RST;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            angle_reg   <= angle_next;
            unc_reg     <= unc_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_STEP_TIME:  step_time_reg  <= cfg_wdata[15:0];
                    REG_PROC_NOISE: proc_noise_reg <= cfg_wdata;
                    REG_MEAS_VAR:   meas_var_reg   <= cfg_wdata;
                    REG_GYRO_SCALE: gyro_scale_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        cnt_reg    <= cnt_next;
        ysq_reg    <= ysq_next;
        rad_reg    <= rad_next;
        srem_reg   <= srem_next;
        root_reg   <= root_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
        meas_reg   <= meas_next;
        pred_reg   <= pred_next;
        p_reg      <= p_next;
        den_reg    <= den_next;
        drem_reg   <= drem_next;
        gain_reg   <= gain_next;
        lo_reg     <= lo_next;
        newa_reg   <= newa_next;
        m_data_reg <= m_data_next;
    end
endmodule

// ===== src/takf_chk.sv =====
// Port-level checks for the tilt angle Kalman fusion block.
// Depends on takf_pkg; bound to the top level at the end of this file.
module takf_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input takf_pkg::takf_out_t m_data
);
    import takf_pkg::*;

    // A word that has just been taken keeps the block busy for the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while previous word still in work");

    // The output register is empty straight after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before it was taken");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result changed while stalled");
endmodule

bind tilt_angle_kalman_fusion takf_chk u_takf_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== verif/tb.sv =====
// Self-checking testbench for tilt_angle_kalman_fusion.
// Depends on src/takf_pkg.sv for the word types and on the block itself; holds its
// own fixed-point predictor of the CORDIC tilt measurement and the Kalman step.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import takf_pkg::*;

    localparam int ITERS      = 16;
    localparam int SETTLE     = 100;   // a little above the time one word occupies the block
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_OFF   = 400;
    localparam logic [2:0] IDX_SPARE_A = 3'd4;
    localparam logic [2:0] IDX_SPARE_B = 3'd7;

    class tilt_scoreboard;
        int unsigned iters;
        logic [15:0] step_time;
        logic [23:0] proc_noise;
        logic [23:0] meas_var;
        logic [23:0] gyro_scale;
        longint      angle_q16;
        longint      unc_q24;
        takf_out_t   expected_q[$];
        longint      atan_tab[24];
        int          errors;
        int          words_in;
        int          words_out;

        function new(int unsigned n);
            atan_tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                         16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                         262143, 131071, 65535, 32767, 16383, 8191,
                         4095, 2047, 1023, 511, 255, 127};
            iters      = (n > 24) ? 24 : n;
            step_time  = STEP_TIME_RST;
            proc_noise = PROC_NOISE_RST;
            meas_var   = MEAS_VAR_RST;
            gyro_scale = GYRO_SCALE_RST;
            angle_q16  = 0;
            unc_q24    = 64'd67108864;
            errors     = 0;
            words_in   = 0;
            words_out  = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [23:0] val);
            case (idx)
                REG_STEP_TIME:  step_time  = val[15:0];
                REG_PROC_NOISE: proc_noise = val;
                REG_MEAS_VAR:   meas_var   = val;
                REG_GYRO_SCALE: gyro_scale = val;
                default: ;
            endcase
        endfunction

        function longint round_away(longint v, int s);
            longint half;
            half = longint'(1) << (s - 1);
            if (v >= 0) return (v + half) >>> s;
            return -(((-v) + half) >>> s);
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint sqrt_floor(longint n);
            longint res;
            longint b;
            res = 0;
            b = longint'(1) << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function longint tilt_q16(longint ax, longint ay, longint az);
            longint x, y, z, xs, ys;
            x = sqrt_floor((ay * ay + az * az) << 16);
            y = ax * 256;
            z = 0;
            if (x == 0) begin
                // Vertical or null vector: no rotation is possible.
                if (y > 0) z = HALF_PI_Q30;
                else if (y < 0) z = -longint'(HALF_PI_Q30);
            end else begin
                for (int i = 0; i < iters; i++) begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y > 0) begin
                        x = x + ys;
                        y = y - xs;
                        z = z + atan_tab[i];
                    end else if (y < 0) begin
                        x = x - ys;
                        y = y + xs;
                        z = z - atan_tab[i];
                    end
                end
            end
            return round_away(z * 64'sd3755213, 30);
        endfunction

        function void note_input(takf_in_t w);
            longint meas, delta, pred, p, den, gain, corr, newa, newp;
            takf_out_t e;
            meas  = tilt_q16(longint'(w.accel_x), longint'(w.accel_y), longint'(w.accel_z));
            delta = round_away(longint'(w.gyro_rate) * longint'(gyro_scale)
                               * longint'(step_time), 24);
            pred  = clamp32(angle_q16 + delta);
            p     = unc_q24 + longint'(proc_noise);
            if (p > 64'sd4294967295) p = 64'sd4294967295;
            den   = p + longint'(meas_var);
            gain  = (den == 0) ? 0 : (p << 24) / den;
            corr  = round_away(gain * (meas - pred), 24);
            newa  = clamp32(pred + corr);
            newp  = (((longint'(1) << 24) - gain) * p + (longint'(1) << 23)) >> 24;
            angle_q16 = newa;
            unc_q24   = newp;
            e.angle_estimate       = newa[31:0];
            e.estimate_uncertainty = newp[31:0];
            expected_q.push_back(e);
            words_in++;
        endfunction

        function void check_result(takf_out_t got);
            takf_out_t e;
            words_out++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result word angle=%h unc=%h", $time,
                         got.angle_estimate, got.estimate_uncertainty);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.angle_estimate !== e.angle_estimate) begin
                $display("%0t: angle_estimate expected %h got %h", $time,
                         e.angle_estimate, got.angle_estimate);
                errors++;
            end
            if (got.estimate_uncertainty !== e.estimate_uncertainty) begin
                $display("%0t: estimate_uncertainty expected %h got %h", $time,
                         e.estimate_uncertainty, got.estimate_uncertainty);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    takf_in_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    takf_out_t   m_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_wdata = '0;

    tilt_scoreboard sb = new(ITERS);
    bit  hold_req = 1'b0;
    bit  no_stall = 1'b0;
    int  idle_cycles = 0;
    int  cfg_writes = 0;

    always #1 aclk = ~aclk;

    tilt_angle_kalman_fusion #(.CORDIC_ITERATIONS(ITERS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("tilt_angle_kalman_fusion regression: fail");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                @(negedge aclk) m_ready <= 1'b0;
                repeat (HOLD_OFF) @(negedge aclk);
                hold_req = 1'b0;
            end else if (no_stall) begin
                @(negedge aclk) m_ready <= 1'b1;
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    @(negedge aclk) m_ready <= 1'b0;
                    repeat (n - 1) @(negedge aclk);
                end
                @(negedge aclk) m_ready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge aclk);
            end
        end
    end

    task automatic send_word(takf_in_t w, int gap);
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= w;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [23:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_writes++;
    endtask

    task automatic cfg_done();
        @(negedge aclk) cfg_we <= 1'b0;
    endtask

    // Sender pauses until every expected word is back, then lets the block settle.
    task automatic drain();
        @(negedge aclk) s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic takf_in_t mk(int ax, int ay, int az, int gr);
        takf_in_t w;
        w.accel_x   = 16'(ax);
        w.accel_y   = 16'(ay);
        w.accel_z   = 16'(az);
        w.gyro_rate = 16'(gr);
        return w;
    endfunction

    function automatic takf_in_t random_word();
        takf_in_t w;
        int mode;
        w = takf_in_t'({$urandom, $urandom});
        mode = $urandom_range(0, 9);
        case (mode)
            0: begin
                w.accel_y = '0;
                w.accel_z = '0;
            end
            1: begin
                w.accel_x = 16'($urandom_range(0, 64) - 32);
                w.accel_y = 16'($urandom_range(0, 64) - 32);
                w.accel_z = 16'($urandom_range(0, 64) - 32);
            end
            2: w.accel_x = '0;
            3: w.gyro_rate = 16'($urandom_range(0, 512) - 256);
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [23:0] pick_val(logic [23:0] lo, logic [23:0] hi,
                                            logic [23:0] dflt);
        case ($urandom_range(0, 4))
            0: return lo;
            1: return hi;
            2: return dflt;
            default: return lo + 24'($urandom % (32'(hi - lo) + 1));
        endcase
    endfunction

    initial begin
        takf_in_t dir_q[$];
        repeat (5) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Directed words at the default settings.
        dir_q = '{mk(0, 0, 0, 0), mk(1000, 0, 0, 100), mk(-1000, 0, 0, -100),
                  mk(0, 5000, -7000, 0), mk(32767, 32767, 32767, 32767),
                  mk(-32768, -32768, -32768, -32768), mk(32767, 0, 0, -32768),
                  mk(-32768, 0, 0, 32767), mk(16384, 0, 16384, 0),
                  mk(-16384, 16384, 0, 1), mk(1, 32767, -32768, -1),
                  mk(-1, -32768, 32767, 0), mk(0, 0, 1, 32767),
                  mk(21845, -10922, 10922, -21846)};
        foreach (dir_q[i]) send_word(dir_q[i], pick_gap());
        drain();

        // Saturate the angle: fastest gyro steps, weakest accelerometer pull.
        cfg_write(REG_STEP_TIME, 24'hFFFFFF);      // upper bits must be dropped
        cfg_write(REG_GYRO_SCALE, 24'hFFFFFF);
        cfg_write(REG_MEAS_VAR, 24'hFFFFFF);
        cfg_write(REG_PROC_NOISE, 24'h000000);
        cfg_write(IDX_SPARE_A, 24'h123456);
        cfg_write(IDX_SPARE_B, 24'hFFFFFF);
        cfg_done();
        repeat (6) send_word(mk(0, 0, 1, 32767), 0);
        repeat (6) send_word(mk(0, 0, 1, -32768), 0);
        drain();

        // R of zero drives P to zero, after which P + R is zero as well.
        cfg_write(REG_MEAS_VAR, 24'd0);
        cfg_write(REG_STEP_TIME, 24'd0);
        cfg_done();
        repeat (4) send_word(mk(3000, 100, 2000, 500), 0);
        drain();

        // Long receiver hold-off while words keep coming.
        cfg_write(REG_STEP_TIME, 24'(STEP_TIME_RST));
        cfg_write(REG_PROC_NOISE, PROC_NOISE_RST);
        cfg_write(REG_MEAS_VAR, MEAS_VAR_RST);
        cfg_write(REG_GYRO_SCALE, GYRO_SCALE_RST);
        cfg_done();
        hold_req = 1'b1;
        repeat (12) send_word(random_word(), 0);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            cfg_write(REG_STEP_TIME, pick_val(24'd0, 24'd65535, 24'(STEP_TIME_RST)));
            cfg_write(REG_PROC_NOISE, pick_val(24'd0, 24'hFFFFFF, PROC_NOISE_RST));
            cfg_write(REG_MEAS_VAR, pick_val(24'd1, 24'hFFFFFF, MEAS_VAR_RST));
            cfg_write(REG_GYRO_SCALE, pick_val(24'd0, 24'hFFFFFF, GYRO_SCALE_RST));
            cfg_done();
            no_stall = (ph == 3);
            for (int k = 0; k < 195; k++) begin
                send_word(random_word(), (ph == 3) ? 0 : pick_gap());
            end
            drain();
        end

        $display("Ran %0d words and %0d results through %0d register writes,",
                 sb.words_in, sb.words_out, cfg_writes);
        $display("covering special vectors, saturation, zero gain and random settings.");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tilt_angle_kalman_fusion regression: pass");
        end else begin
            $display("tilt_angle_kalman_fusion regression: fail");
        end
        $finish;
    end
endmodule
